[hw/rtl/bwg_pkg.sv]
// ----------------------------------------------------------------------------
// bwg_pkg: shared definitions of the waveform generator
// Field widths, register indexes, wave codes and constants used for building
// the sine table.
// ----------------------------------------------------------------------------
package bwg_pkg;

  localparam int unsigned IDX_W      = 32;
  localparam int unsigned FQ_W       = 24;
  localparam int unsigned SR_W       = 20;
  localparam int unsigned DEN_W      = 28;
  localparam int unsigned PROD_W     = 56;
  localparam int unsigned Q_W        = 16;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned WAVE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam int unsigned SINE_ENTRIES_DEFAULT = 1024;

  localparam logic [SR_W-1:0]   SR_RESET   = SR_W'(44100);
  localparam logic [WAVE_W-1:0] WAVE_SINE  = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_SAW   = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd2;
  localparam logic [WAVE_W-1:0] WAVE_TRI   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SELECT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'd1;

  // Pi in Q30 and the divisors (2i)(2i+1) of the Taylor series of sine.
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam int unsigned TAYLOR_DIV [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

endpackage

[hw/rtl/bwg_cell.sv]
// ----------------------------------------------------------------------------
// bwg_cell: one restoring division step
// Shifts the next dividend bit into the remainder, subtracts the divisor when
// it fits and shifts the quotient bit into the dividend word.
// ----------------------------------------------------------------------------
module bwg_cell #(
  parameter int unsigned DW = 28,
  parameter int unsigned NW = 32,
  parameter int unsigned SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] in_rem,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_rem,
  output logic [NW-1:0] out_num,
  output logic [DW-1:0] out_den,
  output logic [SW-1:0] out_side
);

  logic          v;
  logic [DW-1:0] rem;
  logic [NW-1:0] num;
  logic [DW-1:0] den;
  logic [SW-1:0] side;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;
  logic [DW-1:0] rem_next;
  logic [NW-1:0] num_next;

  assign trial    = {in_rem, in_num[NW-1]};
  assign diff     = trial - {1'b0, in_den};
  assign fits     = trial >= {1'b0, in_den};
  assign rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
  assign num_next = {in_num[NW-2:0], fits};

  assign in_ready = !v || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rem  <= rem_next;
      num  <= num_next;
      den  <= in_den;
      side <= in_side;
    end
  end

  assign out_valid = v;
  assign out_rem   = rem;
  assign out_num   = num;
  assign out_den   = den;
  assign out_side  = side;

endmodule

[hw/rtl/bwg_div.sv]
// ----------------------------------------------------------------------------
// bwg_div: pipelined divider
// A row of division cells, one quotient bit per cell, with a payload that
// travels beside the operands.
// ----------------------------------------------------------------------------
module bwg_div #(
  parameter int unsigned DW = 28,
  parameter int unsigned NW = 32,
  parameter int unsigned SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] in_rem,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_rem,
  output logic [NW-1:0] out_quot,
  output logic [DW-1:0] out_den,
  output logic [SW-1:0] out_side
);

  logic [NW:0]         v_c;
  logic [NW:0]         r_c;
  logic [NW:0][DW-1:0] rem_c;
  logic [NW:0][NW-1:0] num_c;
  logic [NW:0][DW-1:0] den_c;
  logic [NW:0][SW-1:0] side_c;

  assign v_c[0]    = in_valid;
  assign in_ready  = r_c[0];
  assign rem_c[0]  = in_rem;
  assign num_c[0]  = in_num;
  assign den_c[0]  = in_den;
  assign side_c[0] = in_side;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    bwg_cell #(.DW(DW), .NW(NW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v_c[i]),
      .in_ready (r_c[i]),
      .in_rem   (rem_c[i]),
      .in_num   (num_c[i]),
      .in_den   (den_c[i]),
      .in_side  (side_c[i]),
      .out_valid(v_c[i+1]),
      .out_ready(r_c[i+1]),
      .out_rem  (rem_c[i+1]),
      .out_num  (num_c[i+1]),
      .out_den  (den_c[i+1]),
      .out_side (side_c[i+1])
    );
  end

  assign r_c[NW]   = out_ready;
  assign out_valid = v_c[NW];
  assign out_rem   = rem_c[NW];
  assign out_quot  = num_c[NW];
  assign out_den   = den_c[NW];
  assign out_side  = side_c[NW];

endmodule

[hw/rtl/bwg_sine_rom.sv]
// ----------------------------------------------------------------------------
// bwg_sine_rom: sine table
// One period of sine in Q14, built at elaboration from a Taylor series, read
// through a registered port.
// ----------------------------------------------------------------------------
module bwg_sine_rom #(
  parameter int unsigned ENTRIES = bwg_pkg::SINE_ENTRIES_DEFAULT,
  parameter int unsigned AW      = $clog2(ENTRIES)
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [AW-1:0]                  addr,
  output logic [bwg_pkg::SAMPLE_W-1:0]   q
);

  localparam logic [63:0] N_ENT = 64'(ENTRIES);
  localparam logic [63:0] TWO_N = 64'(2 * ENTRIES);

  // Quarter-wave symmetry, series evaluated in Q30, rounded half up to Q14.
  function automatic logic [bwg_pkg::SAMPLE_W-1:0] sine_entry(input int unsigned k);
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] res;
    logic        neg;
    u   = 64'(k) << 2;
    neg = 1'b0;
    if (u >= TWO_N) begin
      u   = u - TWO_N;
      neg = 1'b1;
    end
    if (u > N_ENT) begin
      u = TWO_N - u;
    end
    x    = (bwg_pkg::PI_Q30 * u) / TWO_N;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int i = 1; i <= 10; i++) begin
      term = ((term * x2) >> 30) / 64'(bwg_pkg::TAYLOR_DIV[i-1]);
      if (i % 2 == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    res = (sum + 64'd32768) >> 16;
    if (res > 64'd16384) begin
      res = 64'd16384;
    end
    return neg ? bwg_pkg::SAMPLE_W'(64'd0 - res) : bwg_pkg::SAMPLE_W'(res);
  endfunction

  logic [bwg_pkg::SAMPLE_W-1:0] rom [ENTRIES];

  for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
    localparam logic [bwg_pkg::SAMPLE_W-1:0] VAL = sine_entry(k);
    assign rom[k] = VAL;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= rom[addr];
    end
  end

endmodule

[hw/rtl/basic_waveform_generator_unit.sv]
// ----------------------------------------------------------------------------
// basic_waveform_generator_unit: sine, sawtooth, square and triangle samples
// Pipelined oscillator: one Q14 sample per item from a sample index and a
// tone frequency.
// ----------------------------------------------------------------------------
// Usage. Items enter on the s_ channel: s_tdata carries sample_index in bits
// 31:0 and freq_q (Q16.8 hertz) in bits 55:32. Each item gives one result on
// the m_ channel: m_tdata is the Q14 sample, m_tuser flags a zero period, in
// which case the sample is zero. Registers are written through cfg_we,
// cfg_index and cfg_data while no item is in flight.
// Throughput is one item per clock while m_tready stays high. The pipeline
// is the chain of division cells, 28 cells for the period, 32 for the index
// modulo the period, 16 for the position within the period, 56 for the phase
// modulo the sample rate and one per table address bit, plus the input
// register, the multiply register and the output register.
// Reset empties the pipeline and loads wave_select = sine and
// sample_rate = 44100. When the receiver holds m_tready low the result stays
// in the output register and the pipeline keeps taking items until every
// cell ahead of the first empty slot is full; only then does s_tready fall.
// ----------------------------------------------------------------------------
module basic_waveform_generator_unit #(
  parameter int unsigned SINE_TABLE_ENTRIES = bwg_pkg::SINE_ENTRIES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bwg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bwg_pkg::SR_W-1:0]        cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [55:0]                     s_tdata,   // sample_index[31:0], freq_q[55:32]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bwg_pkg::SAMPLE_W-1:0]    m_tdata,   // sample[15:0]
  output logic                            m_tuser    // period_error[0]
);

  localparam int unsigned QB   = $clog2(SINE_TABLE_ENTRIES);
  localparam int unsigned RN_W = bwg_pkg::DEN_W + QB;
  localparam int unsigned IW   = bwg_pkg::IDX_W;
  localparam int unsigned FW   = bwg_pkg::FQ_W;
  localparam int unsigned DNW  = bwg_pkg::DEN_W;
  localparam int unsigned PW   = bwg_pkg::PROD_W;
  localparam int unsigned WW   = bwg_pkg::WAVE_W;
  localparam int unsigned QW   = bwg_pkg::Q_W;
  localparam int unsigned SW1  = IW + PW + DNW + WW + 1;
  localparam int unsigned SW2  = PW + DNW + WW + 1;
  localparam int unsigned SW3  = PW + DNW + WW + 2;
  localparam int unsigned SW4  = QW + WW + 2;
  localparam logic [QB:0]   N_VAL  = (QB+1)'(SINE_TABLE_ENTRIES);
  localparam logic [QB-1:0] TI_MAX = QB'(SINE_TABLE_ENTRIES - 1);

  // Configuration registers.
  logic [WW-1:0]                 wave_sel;
  logic [bwg_pkg::SR_W-1:0]      sample_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_sel    <= bwg_pkg::WAVE_SINE;
      sample_rate <= bwg_pkg::SR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bwg_pkg::CFG_WAVE_SELECT: wave_sel    <= cfg_data[WW-1:0];
        bwg_pkg::CFG_SAMPLE_RATE: sample_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: latches the item, the period numerator and the phase
  // product freq_q * sample_index.
  logic          a_v;
  logic [IW-1:0] a_idx;
  logic [FW-1:0] a_fq;
  logic [DNW-1:0] a_den;
  logic [PW-1:0] a_prod;
  logic [WW-1:0] a_wave;
  logic          d1_in_ready;

  assign s_tready = !a_v || d1_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (s_tready) begin
      a_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_idx  <= s_tdata[31:0];
      a_fq   <= s_tdata[55:32];
      a_den  <= {sample_rate, 8'd0};
      a_prod <= s_tdata[55:32] * s_tdata[31:0];
      a_wave <= wave_sel;
    end
  end

  // Period t0 = den / freq_q.
  logic           d1_v, d2_in_ready;
  logic [FW-1:0]  d1_rem, d1_den;
  logic [DNW-1:0] d1_t0;
  logic [SW1-1:0] d1_side;

  bwg_div #(.DW(FW), .NW(DNW), .SW(SW1)) u_div_period (
    .clk      (clk),
    .rst      (rst),
    .in_valid (a_v),
    .in_ready (d1_in_ready),
    .in_rem   ('0),
    .in_num   (a_den),
    .in_den   (a_fq),
    .in_side  ({a_fq == '0, a_wave, a_den, a_prod, a_idx}),
    .out_valid(d1_v),
    .out_ready(d2_in_ready),
    .out_rem  (d1_rem),
    .out_quot (d1_t0),
    .out_den  (d1_den),
    .out_side (d1_side)
  );

  // m = sample_index mod t0.
  logic           d2_v, d3_in_ready;
  logic [DNW-1:0] d2_m, d2_t0;
  logic [IW-1:0]  d2_quot;
  logic [SW2-1:0] d2_side;
  logic           d2_err, d2_half;

  bwg_div #(.DW(DNW), .NW(IW), .SW(SW2)) u_div_mod (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d1_v),
    .in_ready (d2_in_ready),
    .in_rem   ('0),
    .in_num   (d1_side[IW-1:0]),
    .in_den   (d1_t0),
    .in_side  (d1_side[SW1-1:IW]),
    .out_valid(d2_v),
    .out_ready(d3_in_ready),
    .out_rem  (d2_m),
    .out_quot (d2_quot),
    .out_den  (d2_t0),
    .out_side (d2_side)
  );

  // A zero period comes from a zero frequency or a numerator below it.
  assign d2_err  = d2_side[SW2-1] || (d2_t0 == '0);
  assign d2_half = d2_m < {1'b0, d2_t0[DNW-1:1]};

  // Position within the period: q16 = 65536 * m / t0.
  logic           d3_v, d4_in_ready;
  logic [DNW-1:0] d3_rem, d3_den;
  logic [QW-1:0]  d3_q;
  logic [SW3-1:0] d3_side;

  bwg_div #(.DW(DNW), .NW(QW), .SW(SW3)) u_div_pos (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d2_v),
    .in_ready (d3_in_ready),
    .in_rem   (d2_m),
    .in_num   ('0),
    .in_den   (d2_t0),
    .in_side  ({d2_half, d2_err, d2_side[SW2-2:0]}),
    .out_valid(d3_v),
    .out_ready(d4_in_ready),
    .out_rem  (d3_rem),
    .out_quot (d3_q),
    .out_den  (d3_den),
    .out_side (d3_side)
  );

  // Phase remainder r = (freq_q * sample_index) mod den.
  logic           d4_v, mm_ready;
  logic [DNW-1:0] d4_r, d4_den;
  logic [PW-1:0]  d4_quot;
  logic [SW4-1:0] d4_side;

  bwg_div #(.DW(DNW), .NW(PW), .SW(SW4)) u_div_phase (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d3_v),
    .in_ready (d4_in_ready),
    .in_rem   ('0),
    .in_num   (d3_side[PW-1:0]),
    .in_den   (d3_side[PW+DNW-1:PW]),
    .in_side  ({d3_side[SW3-1:PW+DNW], d3_q}),
    .out_valid(d4_v),
    .out_ready(mm_ready),
    .out_rem  (d4_r),
    .out_quot (d4_quot),
    .out_den  (d4_den),
    .out_side (d4_side)
  );

  // Multiply register: r * SINE_TABLE_ENTRIES, below den << QB.
  logic           mm_v, d5_in_ready;
  logic [RN_W:0]  rn_full;
  logic [RN_W-1:0] mm_rn;
  logic [DNW-1:0] mm_den;
  logic [SW4-1:0] mm_side;

  assign rn_full  = d4_r * N_VAL;
  assign mm_ready = !mm_v || d5_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mm_v <= 1'b0;
    end else if (mm_ready) begin
      mm_v <= d4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (d4_v && mm_ready) begin
      mm_rn   <= rn_full[RN_W-1:0];
      mm_den  <= d4_den;
      mm_side <= d4_side;
    end
  end

  // Table address ti = r * SINE_TABLE_ENTRIES / den.
  logic           d5_v, o_ready;
  logic [DNW-1:0] d5_rem, d5_den;
  logic [QB-1:0]  d5_ti;
  logic [SW4-1:0] d5_side;

  bwg_div #(.DW(DNW), .NW(QB), .SW(SW4)) u_div_addr (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mm_v),
    .in_ready (d5_in_ready),
    .in_rem   (mm_rn[RN_W-1:QB]),
    .in_num   (mm_rn[QB-1:0]),
    .in_den   (mm_den),
    .in_side  (mm_side),
    .out_valid(d5_v),
    .out_ready(o_ready),
    .out_rem  (d5_rem),
    .out_quot (d5_ti),
    .out_den  (d5_den),
    .out_side (d5_side)
  );

  // Sample for the non-sine waves from q16 and the half-period flag.
  logic [QW-1:0]      f_q;
  logic [WW-1:0]      f_wave;
  logic               f_err, f_half;
  logic signed [17:0] saw_v, tri_v, calc_v;
  logic [QB-1:0]      rom_addr;
  logic               o_load;

  assign f_q    = d5_side[QW-1:0];
  assign f_wave = d5_side[QW+WW-1:QW];
  assign f_err  = d5_side[QW+WW];
  assign f_half = d5_side[QW+WW+1];

  assign saw_v = 18'sd16384 - $signed({3'b000, f_q[QW-1:1]});

  always_comb begin
    tri_v = f_half ? $signed({2'b00, f_q}) - 18'sd16384
                   : 18'sd49152 - $signed({2'b00, f_q});
    if (tri_v > 18'sd16384) begin
      tri_v = 18'sd16384;
    end
    unique case (f_wave)
      bwg_pkg::WAVE_SAW:    calc_v = saw_v;
      bwg_pkg::WAVE_SQUARE: calc_v = f_half ? 18'sd16384 : -18'sd16384;
      bwg_pkg::WAVE_TRI:    calc_v = tri_v;
      default:              calc_v = '0;
    endcase
  end

  assign rom_addr = (d5_ti > TI_MAX) ? TI_MAX : d5_ti;
  assign o_load   = d5_v && o_ready;

  // Output register; the table read lands in the same cycle.
  logic                         o_v, o_err, o_sine;
  logic [bwg_pkg::SAMPLE_W-1:0] o_calc, rom_q;

  bwg_sine_rom #(.ENTRIES(SINE_TABLE_ENTRIES), .AW(QB)) u_sine_rom (
    .clk (clk),
    .en  (o_load),
    .addr(rom_addr),
    .q   (rom_q)
  );

  assign o_ready = !o_v || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (o_ready) begin
      o_v <= d5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_calc <= calc_v[bwg_pkg::SAMPLE_W-1:0];
      o_err  <= f_err;
      o_sine <= f_wave == bwg_pkg::WAVE_SINE;
    end
  end

  assign m_tvalid = o_v;
  assign m_tuser  = o_err;
  assign m_tdata  = o_err ? '0 : (o_sine ? rom_q : o_calc);

  // An empty output register lets the whole chain move, so input is open.
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked while the output register is empty");

  a_error_zero_sample: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("zero period result carries a nonzero sample");

  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata) <= 16'sd16384) && ($signed(m_tdata) >= -16'sd16384))
    else $error("sample outside plus or minus one");

  a_reset_config: assert property (@(posedge clk)
    $past(rst) && !rst |->
      (wave_sel == bwg_pkg::WAVE_SINE) && (sample_rate == bwg_pkg::SR_RESET))
    else $error("configuration not at reset values after reset");

endmodule
